@@ rtl/bitmap_contiguous_page_allocator_core_macros.svh @@
// ----------------------------------------------------------------------------
// bitmap page allocator assertion macros
// shared property forms, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef BITMAP_CONTIGUOUS_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_CONTIGUOUS_PAGE_ALLOCATOR_CORE_MACROS_SVH

// consequent checked in the same cycle
`define BCPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define BCPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bcpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpa_pkg
// shared types, field widths and codes of the bitmap page allocator
// ----------------------------------------------------------------------------
package bcpa_pkg;

  localparam int DEF_NUM_PAGES = 16384;
  localparam int DEF_WORD_BITS = 32;

  localparam int KIND_W  = 2;
  localparam int PAGE_FW = 14;
  localparam int CNT_W   = 15;
  localparam int STAT_W  = 2;
  localparam int IN_DW   = 32;
  localparam int OUT_DW  = 16;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 32;

  localparam logic [PAGE_FW-1:0] DEF_SEARCH_BASE = PAGE_FW'(4096);
  localparam logic [CFG_AW-1:0]  REG_SEARCH_BASE = '0;

  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_ZERO    = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_INIT,
    ST_SCAN,
    ST_MARK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic  clr;
    logic  take;
    logic  found;
    logic  walk_init;
    logic  walk_run;
    logic  mark;
    logic  res_set;
    stat_t res_status;
    logic  res_alloc;
  } ctrl_cmd_t;

  typedef struct packed {
    logic              clr_last;
    logic [KIND_W-1:0] kind;
    logic              zero;
    logic              oob;
    logic              hit;
    logic              scan_end;
    logic              mark_end;
    logic              out_busy;
  } dp_stat_t;

endpackage

@@ rtl/bcpa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpa_ctrl
// sequencer: clearing pass, request check, word setup, scan, mark and response
// ----------------------------------------------------------------------------
module bcpa_ctrl
  import bcpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  dp_stat_t  st,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;
  stat_t  stat_r, stat_nxt;
  logic   mark_ph_r, mark_ph_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      stat_r    <= STAT_DONE;
      mark_ph_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      stat_r    <= stat_nxt;
      mark_ph_r <= mark_ph_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    stat_nxt    = stat_r;
    mark_ph_nxt = mark_ph_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (st.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (st.zero) begin
          stat_nxt  = STAT_ZERO;
          state_nxt = ST_RESP;
        end else if (st.kind != KIND_ALLOC && st.kind != KIND_FREE &&
                     st.kind != KIND_RESERVE) begin
          stat_nxt  = STAT_DONE;
          state_nxt = ST_RESP;
        end else if (st.oob) begin
          stat_nxt  = (st.kind == KIND_ALLOC) ? STAT_NOSPACE : STAT_DONE;
          state_nxt = ST_RESP;
        end else begin
          mark_ph_nxt = (st.kind != KIND_ALLOC);
          state_nxt   = ST_INIT;
        end
      end
      ST_INIT: begin
        state_nxt = mark_ph_r ? ST_MARK : ST_SCAN;
      end
      ST_SCAN: begin
        priority if (st.hit) begin
          mark_ph_nxt = 1'b1;
          state_nxt   = ST_INIT;
        end else if (st.scan_end) begin
          stat_nxt  = STAT_NOSPACE;
          state_nxt = ST_RESP;
        end
      end
      ST_MARK: begin
        if (st.mark_end) begin
          stat_nxt  = STAT_DONE;
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!st.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.res_status = stat_r;
    in_tready      = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clr = 1'b1;
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
      end
      ST_CHECK: ;
      ST_INIT:  cmd.walk_init = 1'b1;
      ST_SCAN: begin
        cmd.walk_run = 1'b1;
        cmd.found    = st.hit;
      end
      ST_MARK: begin
        cmd.walk_run = 1'b1;
        cmd.mark     = 1'b1;
      end
      ST_RESP: begin
        cmd.res_set   = !st.out_busy;
        cmd.res_alloc = (st.kind == KIND_ALLOC) && (stat_r == STAT_DONE);
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/bcpa_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcpa_datapath
// bitmap memory, page to word split, word scan and range mark, result register
// ----------------------------------------------------------------------------
module bcpa_datapath
  import bcpa_pkg::*;
#(
  parameter int NUM_PAGES = DEF_NUM_PAGES,
  parameter int WORD_BITS = DEF_WORD_BITS  // power of two
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_cmd_t          cmd,
  output dp_stat_t           st,
  input  logic [PAGE_FW-1:0] search_base,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [PAGE_FW-1:0] in_first,
  input  logic [CNT_W-1:0]   in_count,
  output logic               out_valid,
  input  logic               out_ready,
  output stat_t              out_status,
  output logic [PAGE_FW-1:0] out_start
);

  localparam int WORD_COUNT = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int PG_W       = $clog2(NUM_PAGES + 1);
  localparam int SUM_W      = ((PG_W > CNT_W) ? PG_W : CNT_W) + 1;
  localparam int BIDX_W     = $clog2(WORD_BITS);
  localparam int LAST_BITS  = NUM_PAGES - (WORD_COUNT - 1) * WORD_BITS;
  localparam logic [WADDR_W-1:0] LAST_ADDR = WADDR_W'(WORD_COUNT - 1);
  localparam logic [SUM_W-1:0]   NUM_S     = SUM_W'(NUM_PAGES);
  localparam logic [SUM_W-1:0]   WB_S      = SUM_W'(WORD_BITS);

  logic [WORD_BITS-1:0] mem [WORD_COUNT];

  logic [KIND_W-1:0]    kind_r;
  logic [CNT_W-1:0]     count_r;
  logic [SUM_W-1:0]     page_r;
  logic [WADDR_W-1:0]   addr_r;
  logic [WADDR_W-1:0]   qword_r;
  logic [WADDR_W-1:0]   clr_addr_r;
  logic                 issue_r;
  logic                 qv_r;
  logic                 first_r;
  logic [BIDX_W-1:0]    lo_r;
  logic [SUM_W-1:0]     base_r;
  logic [SUM_W-1:0]     run_r;
  logic [WORD_BITS-1:0] mem_q_r;
  stat_t                res_status_r;
  logic [PAGE_FW-1:0]   res_start_r;
  logic                 out_valid_r;

  logic [SUM_W-1:0]     take_page;
  logic                 rd_en;
  logic                 eval;
  logic [BIDX_W-1:0]    lo_eff;
  logic [WORD_BITS-1:0] used_m;
  logic [SUM_W-1:0]     run_v [WORD_BITS];
  logic [WORD_BITS-1:0] hit_v;
  logic [BIDX_W-1:0]    hit_idx;
  logic [SUM_W-1:0]     found_start;
  logic [SUM_W-1:0]     end_sum;
  logic [SUM_W-1:0]     end_c;
  logic [SUM_W-1:0]     lim;
  logic [WORD_BITS-1:0] mark_m;
  logic [WORD_BITS-1:0] mark_wd;
  logic                 mem_we;
  logic [WADDR_W-1:0]   mem_wa;
  logic [WORD_BITS-1:0] mem_wd;

  assign take_page = (in_kind == KIND_ALLOC) ? SUM_W'(search_base) : SUM_W'(in_first);

  assign rd_en  = cmd.walk_run & issue_r;
  assign eval   = cmd.walk_run & qv_r;
  assign lo_eff = first_r ? lo_r : '0;

  // free run ending at each bit of the current word
  always_comb begin
    logic              any_u;
    logic [BIDX_W-1:0] hp;
    for (int i = 0; i < WORD_BITS; i++) begin
      used_m[i] = mem_q_r[i] | (BIDX_W'(i) < lo_eff) |
                  ((qword_r == LAST_ADDR) && (i >= LAST_BITS));
    end
    for (int i = 0; i < WORD_BITS; i++) begin
      any_u = 1'b0;
      hp    = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
        if (j <= i && used_m[j]) begin
          any_u = 1'b1;
          hp    = BIDX_W'(j);
        end
      end
      run_v[i] = any_u ? (SUM_W'(i) - SUM_W'(hp)) : (run_r + SUM_W'(i + 1));
      hit_v[i] = run_v[i] >= SUM_W'(count_r);
    end
    hit_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (hit_v[i]) hit_idx = BIDX_W'(i);
    end
  end

  assign found_start = base_r + SUM_W'(hit_idx) + SUM_W'(1) - SUM_W'(count_r);

  // range mark mask, clipped to the end of the bitmap
  assign end_sum = page_r + SUM_W'(count_r);
  assign end_c   = (end_sum > NUM_S) ? NUM_S : end_sum;
  assign lim     = end_c - base_r;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      mark_m[i] = (BIDX_W'(i) >= lo_eff) && (SUM_W'(i) < lim);
    end
  end

  assign mark_wd = (kind_r == KIND_FREE) ? (mem_q_r & ~mark_m) : (mem_q_r | mark_m);

  assign mem_we = cmd.clr | (eval & cmd.mark);
  assign mem_wa = cmd.clr ? clr_addr_r : qword_r;
  assign mem_wd = cmd.clr ? '0 : mark_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en)  mem_q_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      qv_r        <= 1'b0;
      issue_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_addr_r <= clr_addr_r + WADDR_W'(1);
      qv_r <= rd_en;
      if (cmd.walk_init) begin
        issue_r <= 1'b1;
      end else if (rd_en) begin
        issue_r <= (addr_r != LAST_ADDR);
      end
      if (cmd.res_set) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_r  <= in_kind;
      count_r <= in_count;
      page_r  <= take_page;
    end else if (cmd.found) begin
      page_r  <= found_start;
    end
    // word index and bit offset of the start page
    if (cmd.walk_init) begin
      addr_r  <= WADDR_W'(page_r >> BIDX_W);
      first_r <= 1'b1;
      lo_r    <= page_r[BIDX_W-1:0];
      base_r  <= page_r - SUM_W'(page_r[BIDX_W-1:0]);
      run_r   <= '0;
    end else begin
      if (rd_en) begin
        qword_r <= addr_r;
        if (addr_r != LAST_ADDR) addr_r <= addr_r + WADDR_W'(1);
      end
      if (eval) begin
        first_r <= 1'b0;
        base_r  <= base_r + WB_S;
        run_r   <= run_v[WORD_BITS-1];
      end
    end
    if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
      res_start_r  <= cmd.res_alloc ? page_r[PAGE_FW-1:0] : '0;
    end
  end

  always_comb begin
    st          = '0;
    st.clr_last = (clr_addr_r == LAST_ADDR);
    st.kind     = kind_r;
    st.zero     = (count_r == '0);
    st.oob      = (page_r >= NUM_S);
    st.hit      = eval & ~cmd.mark & (|hit_v);
    st.scan_end = eval & ~cmd.mark & ~(|hit_v) & (qword_r == LAST_ADDR);
    st.mark_end = eval & cmd.mark & ((base_r + WB_S) >= end_c);
    st.out_busy = out_valid_r & ~out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_status = res_status_r;
  assign out_start  = res_start_r;

endmodule

@@ rtl/bitmap_contiguous_page_allocator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_contiguous_page_allocator_core
// first-fit page allocator over a one-bit-per-page bitmap held in memory
// ----------------------------------------------------------------------------
// reset: clearing pass of one bitmap word per cycle (512 words by default), no input taken
// sequence: zero count, unused kind or start past the end go from the check to the result;
//   free or reserve set up the start word, then mark the words touched; no space scans to the last word
// allocate scans, sets up the word of the found start again, then marks the words touched
// throughput: one item at a time, next beat taken the cycle after the result is set
`include "bitmap_contiguous_page_allocator_core_macros.svh"

module bitmap_contiguous_page_allocator_core
  import bcpa_pkg::*;
#(
  parameter int NUM_PAGES = DEF_NUM_PAGES,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // first_page, page_count
  input  logic [KIND_W-1:0] in_tuser,   // kind
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // start_page
  output logic [STAT_W-1:0] out_tuser,  // status
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  ctrl_cmd_t          cmd;
  dp_stat_t           st;
  logic [PAGE_FW-1:0] search_base_r;
  logic [PAGE_FW-1:0] out_start;
  stat_t              out_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_base_r <= DEF_SEARCH_BASE;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == REG_SEARCH_BASE) begin
      search_base_r <= cfg_pwdata[PAGE_FW-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_SEARCH_BASE) ? CFG_DW'(search_base_r) : '0;

  bcpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  bcpa_datapath #(
    .NUM_PAGES (NUM_PAGES),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .search_base (search_base_r),
    .in_kind     (in_tuser),
    .in_first    (in_tdata[PAGE_FW-1:0]),
    .in_count    (in_tdata[PAGE_FW+CNT_W-1:PAGE_FW]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (out_status),
    .out_start   (out_start)
  );

  assign out_tdata = OUT_DW'(out_start);
  assign out_tuser = out_status;

  `BCPA_ASSERT_NEXT(a_busy_after_take, in_tvalid && in_tready, !in_tready, "beat taken while busy")
  `BCPA_ASSERT_NOW(a_status_code, out_tvalid, out_tuser == STAT_DONE || out_tuser == STAT_NOSPACE || out_tuser == STAT_ZERO, "bad status code")
  `BCPA_ASSERT_NOW(a_start_zero, out_tvalid && out_tuser != STAT_DONE, out_tdata == '0, "start page set on failure")

endmodule
